[hw/rtl/block_table_fit_allocator_defines.svh]
// ----------------------------------------------------------------------------
// block table fit allocator: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BLOCK_TABLE_FIT_ALLOCATOR_DEFINES_SVH
`define BLOCK_TABLE_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, idle during reset
`define BFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// types and constants shared by the block table fit allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int HEADER_BYTES = 32;
    localparam int HEAP_BYTES   = 1048576;
    localparam int SIZE_W       = 16;
    localparam int OFF_W        = 20;
    localparam int LIMIT_W      = 21;
    localparam int TOP_W        = 21;
    localparam int NEED_W       = SIZE_W + 1;

    localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = LIMIT_W'(HEAP_BYTES);

    typedef enum logic [2:0] {
        ST_REUSED  = 3'd0,
        ST_GROWN   = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_ZERO    = 3'd3,
        ST_FREED   = 3'd4,
        ST_BADFREE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } policy_t;

    typedef enum logic [0:0] {
        REG_FIT_POLICY = 1'b0,
        REG_HEAP_LIMIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
        logic              free;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  idx;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } result_t;

endpackage

[hw/rtl/bfa_table.sv]
// ----------------------------------------------------------------------------
// bfa_table
// block table memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bfa_table (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [bfa_pkg::IDX_W-1:0]     rd_addr,
    output bfa_pkg::entry_t               rd_data,
    input  bfa_pkg::mem_wr_t              wr
);

    bfa_pkg::entry_t mem [bfa_pkg::MAX_BLOCKS];
    bfa_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/bfa_ctrl.sv]
// ----------------------------------------------------------------------------
// bfa_ctrl
// item sequencer: table scan, fit selection, growth and free handling
// ----------------------------------------------------------------------------
module bfa_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    // item side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_mode,
    input  logic [bfa_pkg::SIZE_W-1:0]    in_req,
    input  logic [bfa_pkg::IDX_W-1:0]     in_idx,
    // configuration
    input  bfa_pkg::policy_t              fit_policy,
    input  logic [bfa_pkg::LIMIT_W-1:0]   heap_limit,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output bfa_pkg::result_t              res,
    // table memory
    output logic                          mem_rd_en,
    output logic [bfa_pkg::IDX_W-1:0]     mem_rd_addr,
    input  bfa_pkg::entry_t               mem_rd_data,
    output bfa_pkg::mem_wr_t              mem_wr
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_FREE_CHK = 5'b00010,
        S_SCAN     = 5'b00100,
        S_FINISH   = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    localparam int IW = bfa_pkg::IDX_W;
    localparam int CW = bfa_pkg::CNT_W;
    localparam int SW = bfa_pkg::SIZE_W;
    localparam int OW = bfa_pkg::OFF_W;
    localparam int TW = bfa_pkg::TOP_W;

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] a,
                                                input logic [CW-1:0] cnt);
        logic [CW-1:0] n;
        n = {1'b0, a} + CW'(1);
        wrap_next = (n == cnt) ? '0 : n[IW-1:0];
    endfunction

    // control state
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [TW-1:0]  top_reg, top_next;
    logic [IW-1:0]  rover_reg, rover_next;
    logic [CW-1:0]  iss_left_reg, iss_left_next;
    logic [CW-1:0]  chk_left_reg, chk_left_next;
    logic           found_reg, found_next;

    // payload
    logic [SW-1:0]  need_reg, need_next;
    logic [IW-1:0]  iss_addr_reg, iss_addr_next;
    logic [IW-1:0]  chk_addr_reg, chk_addr_next;
    logic [IW-1:0]  pick_idx_reg, pick_idx_next;
    logic [SW-1:0]  pick_size_reg, pick_size_next;
    logic [OW-1:0]  pick_off_reg, pick_off_next;
    bfa_pkg::result_t res_reg, res_next;
    bfa_pkg::mem_wr_t wr_reg, wr_next;

    logic [bfa_pkg::NEED_W-1:0] need_round;
    logic [IW-1:0]  scan_start;
    logic           fit;
    logic           take;
    logic           first_like;
    logic [TW:0]    newtop;
    logic [bfa_pkg::LIMIT_W-1:0] limit;

    assign need_round = ({1'b0, in_req} + bfa_pkg::NEED_W'(3))
                        & ~bfa_pkg::NEED_W'(3);
    assign first_like = (fit_policy == bfa_pkg::FIT_FIRST)
                        || (fit_policy == bfa_pkg::FIT_NEXT);
    assign scan_start = ((fit_policy == bfa_pkg::FIT_NEXT)
                         && ({1'b0, rover_reg} < count_reg)) ? rover_reg : '0;
    assign fit  = mem_rd_data.free && (mem_rd_data.size >= need_reg);
    assign take = fit && (first_like || !found_reg
                  || ((fit_policy == bfa_pkg::FIT_BEST)
                      && (mem_rd_data.size < pick_size_reg))
                  || ((fit_policy == bfa_pkg::FIT_WORST)
                      && (mem_rd_data.size > pick_size_reg)));
    assign newtop = {1'b0, top_reg} + (TW+1)'(bfa_pkg::HEADER_BYTES)
                    + (TW+1)'(need_reg);
    assign limit = (heap_limit < bfa_pkg::HEAP_LIMIT_RST) ? heap_limit
                                                         : bfa_pkg::HEAP_LIMIT_RST;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        rover_next     = rover_reg;
        iss_left_next  = iss_left_reg;
        chk_left_next  = chk_left_reg;
        found_next     = found_reg;
        need_next      = need_reg;
        iss_addr_next  = iss_addr_reg;
        chk_addr_next  = chk_addr_reg;
        pick_idx_next  = pick_idx_reg;
        pick_size_next = pick_size_reg;
        pick_off_next  = pick_off_reg;
        res_next       = res_reg;
        wr_next        = wr_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = iss_addr_reg;
        mem_wr         = wr_reg;
        mem_wr.en      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next   = '0;
                    wr_next    = '0;
                    found_next = 1'b0;
                    if (in_mode)
                    begin
                        chk_addr_next = in_idx;
                        if ({1'b0, in_idx} >= count_reg)
                        begin
                            res_next.status = bfa_pkg::ST_BADFREE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = in_idx;
                            state_next  = S_FREE_CHK;
                        end
                    end
                    else if (need_round == '0)
                    begin
                        res_next.status = bfa_pkg::ST_ZERO;
                        state_next      = S_DONE;
                    end
                    else if (need_round[bfa_pkg::NEED_W-1])
                    begin
                        // rounds past the largest block size
                        res_next.status = bfa_pkg::ST_NOSPACE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        need_next = need_round[SW-1:0];
                        if (count_reg == '0)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            mem_rd_en     = 1'b1;
                            mem_rd_addr   = scan_start;
                            chk_addr_next = scan_start;
                            iss_addr_next = wrap_next(scan_start, count_reg);
                            iss_left_next = count_reg - CW'(1);
                            chk_left_next = count_reg;
                            state_next    = S_SCAN;
                        end
                    end
                end
            end

            S_FREE_CHK:
            begin
                if (mem_rd_data.free)
                begin
                    res_next.status = bfa_pkg::ST_BADFREE;
                end
                else
                begin
                    res_next.status   = bfa_pkg::ST_FREED;
                    res_next.idx      = chk_addr_reg;
                    res_next.offset   = mem_rd_data.offset + OW'(bfa_pkg::HEADER_BYTES);
                    res_next.size     = mem_rd_data.size;
                    wr_next.en        = 1'b1;
                    wr_next.addr      = chk_addr_reg;
                    wr_next.data      = mem_rd_data;
                    wr_next.data.free = 1'b1;
                end
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                // one read issued and one entry checked per cycle
                if (iss_left_reg != '0)
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = iss_addr_reg;
                    chk_addr_next = iss_addr_reg;
                    iss_addr_next = wrap_next(iss_addr_reg, count_reg);
                    iss_left_next = iss_left_reg - CW'(1);
                end
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_idx_next  = chk_addr_reg;
                    pick_size_next = mem_rd_data.size;
                    pick_off_next  = mem_rd_data.offset;
                end
                chk_left_next = chk_left_reg - CW'(1);
                if ((fit && first_like) || (chk_left_reg == CW'(1)))
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (found_reg)
                begin
                    res_next.status = bfa_pkg::ST_REUSED;
                    res_next.idx    = pick_idx_reg;
                    res_next.offset = pick_off_reg + OW'(bfa_pkg::HEADER_BYTES);
                    res_next.size   = pick_size_reg;
                    wr_next.en      = 1'b1;
                    wr_next.addr    = pick_idx_reg;
                    wr_next.data    = '{size: pick_size_reg, offset: pick_off_reg,
                                        free: 1'b0};
                    rover_next      = pick_idx_reg;
                end
                else if ((count_reg >= CW'(bfa_pkg::MAX_BLOCKS))
                         || (newtop > {1'b0, limit}))
                begin
                    res_next.status = bfa_pkg::ST_NOSPACE;
                end
                else
                begin
                    res_next.status = bfa_pkg::ST_GROWN;
                    res_next.idx    = count_reg[IW-1:0];
                    res_next.offset = top_reg[OW-1:0] + OW'(bfa_pkg::HEADER_BYTES);
                    res_next.size   = need_reg;
                    wr_next.en      = 1'b1;
                    wr_next.addr    = count_reg[IW-1:0];
                    wr_next.data    = '{size: need_reg, offset: top_reg[OW-1:0],
                                        free: 1'b0};
                    count_next      = count_reg + CW'(1);
                    top_next        = newtop[TW-1:0];
                    rover_next      = count_reg[IW-1:0];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // table update lands with the result transfer
                if (res_ready)
                begin
                    mem_wr.en  = wr_reg.en;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            top_reg      <= '0;
            rover_reg    <= '0;
            iss_left_reg <= '0;
            chk_left_reg <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            top_reg      <= top_next;
            rover_reg    <= rover_next;
            iss_left_reg <= iss_left_next;
            chk_left_reg <= chk_left_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg      <= need_next;
        iss_addr_reg  <= iss_addr_next;
        chk_addr_reg  <= chk_addr_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
        pick_off_reg  <= pick_off_next;
        res_reg       <= res_next;
        wr_reg        <= wr_next;
    end

endmodule

[hw/rtl/block_table_fit_allocator.sv]
// ----------------------------------------------------------------------------
// block_table_fit_allocator
// heap block table with first, next, best and worst fit allocation and free
// ----------------------------------------------------------------------------
// sequence: an allocate scans table entries, then reuses a block, grows the
//   heap or fails in a finish step; a free reads its entry before the result;
//   zero size, oversize or a free beyond the table go straight to the result
// throughput: one item at a time; the scan reads one entry per cycle from the table memory
// reset: counts, heap top, rover and config registers return to their reset
//   values at once; table contents need no clearing pass
module block_table_fit_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // item stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // request_size[15:0], block_index[21:16], zero fill
    input  logic        s_axis_tuser,   // mode
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // granted_index[5:0], data_offset[25:6],
                                        // granted_size[41:26], zero fill
    output logic [2:0]  m_axis_tuser,   // status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [20:0] cfg_data
);

    // configuration registers
    bfa_pkg::policy_t            policy_reg, policy_next;
    logic [bfa_pkg::LIMIT_W-1:0] limit_reg, limit_next;

    // output register, frees the sequencer while a result waits
    logic             m_valid_reg, m_valid_next;
    bfa_pkg::result_t m_res_reg, m_res_next;

    logic             res_valid;
    logic             res_ready;
    bfa_pkg::result_t res;

    logic                        mem_rd_en;
    logic [bfa_pkg::IDX_W-1:0]   mem_rd_addr;
    bfa_pkg::entry_t             mem_rd_data;
    bfa_pkg::mem_wr_t            mem_wr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        policy_next = policy_reg;
        limit_next  = limit_reg;
        if (cfg_valid)
        begin
            case (bfa_pkg::cfg_reg_t'(cfg_index))
                bfa_pkg::REG_FIT_POLICY: policy_next = bfa_pkg::policy_t'(cfg_data[1:0]);
                bfa_pkg::REG_HEAP_LIMIT: limit_next  = cfg_data;
                default:                 limit_next  = limit_reg;
            endcase
        end
    end

    // result slot takes a new transfer when empty or draining this cycle
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= bfa_pkg::FIT_FIRST;
            limit_reg   <= bfa_pkg::HEAP_LIMIT_RST;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            policy_reg  <= policy_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_res_reg.status;
    assign m_axis_tdata  = {6'd0, m_res_reg.size, m_res_reg.offset, m_res_reg.idx};

    // sequencer
    bfa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (s_axis_tuser),
        .in_req      (s_axis_tdata[15:0]),
        .in_idx      (s_axis_tdata[21:16]),
        .fit_policy  (policy_reg),
        .heap_limit  (limit_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr      (mem_wr)
    );

    // block table
    bfa_table u_table (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr      (mem_wr)
    );

endmodule

[hw/rtl/bfa_checker.sv]
// ----------------------------------------------------------------------------
// bfa_checker
// port-level checks for the block table fit allocator
// ----------------------------------------------------------------------------
`include "block_table_fit_allocator_defines.svh"

module bfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic fail_code;
    logic grant_code;

    assign fail_code  = (m_axis_tuser == bfa_pkg::ST_NOSPACE)
                        || (m_axis_tuser == bfa_pkg::ST_ZERO)
                        || (m_axis_tuser == bfa_pkg::ST_BADFREE);
    assign grant_code = (m_axis_tuser == bfa_pkg::ST_REUSED)
                        || (m_axis_tuser == bfa_pkg::ST_GROWN);

    // a stalled result holds
    `BFA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // one item at a time: busy after every input transfer
    `BFA_ASSERT_NEXT(a_busy_after_in, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in progress")

    // failures carry all-zero fields
    `BFA_ASSERT_NOW(a_fail_zero, clk, rst_n, m_axis_tvalid && fail_code, m_axis_tdata == 48'd0, "failure result with non-zero fields")

    // granted blocks are non-empty multiples of four bytes
    `BFA_ASSERT_NOW(a_grant_size, clk, rst_n, m_axis_tvalid && grant_code, (m_axis_tdata[27:26] == 2'd0) && (m_axis_tdata[41:26] != 16'd0), "granted size not a non-zero multiple of four")

endmodule

bind block_table_fit_allocator bfa_checker u_bfa_checker (.*);
